>>> rtl/tgi_pkg.sv
// Shared constants, codes and control types of the trilinear grid interpolator.
`timescale 1ns / 1ps
package tgi_pkg;

  localparam int MAX_NODES_DEF = 16;
  localparam int VALUE_BITS_DEF = 32;
  localparam int SAMPLE_DEPTH = 4096;
  localparam int SMP_AW = 12;
  localparam int WGT_W = 17;
  localparam logic [WGT_W-1:0] ONE_Q16 = 17'h10000;
  localparam int CNT_W = 5;
  localparam int CFG_IDX_W = 2;
  localparam int DIV_STEPS = 16;

  localparam logic [2:0] OP_WR_X = 3'd0;
  localparam logic [2:0] OP_WR_Y = 3'd1;
  localparam logic [2:0] OP_WR_Z = 3'd2;
  localparam logic [2:0] OP_WR_SAMPLE = 3'd3;
  localparam logic [2:0] OP_QUERY = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_X_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Z_COUNT = 2'd2;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic [4:0] {
    CMD_IDLE,
    CMD_AXIS_FIRST,
    CMD_FIRST_CHK,
    CMD_LAST_CHK,
    CMD_MID_RD,
    CMD_MID_CHK,
    CMD_RD_LO,
    CMD_RD_HI,
    CMD_DIV_INIT,
    CMD_DIV_STEP,
    CMD_AXIS_END,
    CMD_BASE1,
    CMD_BASE2,
    CMD_BL_RDA,
    CMD_BL_RDB,
    CMD_BL_SUB,
    CMD_BL_MUL,
    CMD_BL_ADD,
    CMD_FINISH
  } cmd_e;

  typedef struct packed {
    logic grid_bad;
    logic q_le_rd;
    logic q_ge_rd;
    logic search_done;
    logic div_busy;
    logic last_axis;
    logic last_blend;
    logic can_publish;
  } dp_status_t;

endpackage

>>> rtl/tgi_in_if.sv
// Input item channel: valid/ready handshake with the request payload.
`timescale 1ns / 1ps
interface tgi_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [11:0] address;
  logic signed [31:0] write_value;
  logic signed [31:0] query_x;
  logic signed [31:0] query_y;
  logic signed [31:0] query_z;

  modport source (output valid, operation, address, write_value, query_x, query_y, query_z,
                  input ready);
  modport sink (input valid, operation, address, write_value, query_x, query_y, query_z,
                output ready);
endinterface

>>> rtl/tgi_out_if.sv
// Result channel: valid/ready handshake with the interpolation result.
`timescale 1ns / 1ps
interface tgi_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] interp_value;
  logic        grid_invalid;

  modport source (output valid, interp_value, grid_invalid, input ready);
  modport sink (input valid, interp_value, grid_invalid, output ready);
endinterface

>>> rtl/tgi_ctrl.sv
// Sequencing state machine: search, weight division and blend phases.
`timescale 1ns / 1ps
module tgi_ctrl
  import tgi_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       query_start_i,
  input  dp_status_t status_i,
  output cmd_e       cmd_o,
  output logic       in_ready_o
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_FIRST, ST_FIRST_CHK, ST_LAST_CHK, ST_MID, ST_MID_CHK, ST_RD_LO,
    ST_RD_HI, ST_DIV_INIT, ST_DIV, ST_AXIS_END, ST_BASE1, ST_BASE2, ST_BL_RDA,
    ST_BL_RDB, ST_BL_SUB, ST_BL_MUL, ST_BL_ADD, ST_FINISH
  } state_e;

  state_e state_q;
  cmd_e   cmd_q;
  logic   ready_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cmd_q   <= CMD_IDLE;
      ready_q <= 1'b1;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (query_start_i) begin
            ready_q <= 1'b0;
            if (status_i.grid_bad) begin
              state_q <= ST_FINISH;
              cmd_q   <= CMD_FINISH;
            end else begin
              state_q <= ST_FIRST;
              cmd_q   <= CMD_AXIS_FIRST;
            end
          end
        end
        ST_FIRST: begin
          state_q <= ST_FIRST_CHK;
          cmd_q   <= CMD_FIRST_CHK;
        end
        ST_FIRST_CHK: begin
          if (status_i.q_le_rd) begin
            state_q <= ST_RD_LO;
            cmd_q   <= CMD_RD_LO;
          end else begin
            state_q <= ST_LAST_CHK;
            cmd_q   <= CMD_LAST_CHK;
          end
        end
        ST_LAST_CHK: begin
          if (status_i.q_ge_rd) begin
            state_q <= ST_RD_LO;
            cmd_q   <= CMD_RD_LO;
          end else begin
            state_q <= ST_MID;
            cmd_q   <= CMD_MID_RD;
          end
        end
        ST_MID: begin
          if (status_i.search_done) begin
            state_q <= ST_RD_LO;
            cmd_q   <= CMD_RD_LO;
          end else begin
            state_q <= ST_MID_CHK;
            cmd_q   <= CMD_MID_CHK;
          end
        end
        ST_MID_CHK: begin
          state_q <= ST_MID;
          cmd_q   <= CMD_MID_RD;
        end
        ST_RD_LO: begin
          state_q <= ST_RD_HI;
          cmd_q   <= CMD_RD_HI;
        end
        ST_RD_HI: begin
          state_q <= ST_DIV_INIT;
          cmd_q   <= CMD_DIV_INIT;
        end
        ST_DIV_INIT: begin
          state_q <= ST_DIV;
          cmd_q   <= CMD_DIV_STEP;
        end
        ST_DIV: begin
          if (!status_i.div_busy) begin
            state_q <= ST_AXIS_END;
            cmd_q   <= CMD_AXIS_END;
          end
        end
        ST_AXIS_END: begin
          if (status_i.last_axis) begin
            state_q <= ST_BASE1;
            cmd_q   <= CMD_BASE1;
          end else begin
            state_q <= ST_FIRST;
            cmd_q   <= CMD_AXIS_FIRST;
          end
        end
        ST_BASE1: begin
          state_q <= ST_BASE2;
          cmd_q   <= CMD_BASE2;
        end
        ST_BASE2: begin
          state_q <= ST_BL_RDA;
          cmd_q   <= CMD_BL_RDA;
        end
        ST_BL_RDA: begin
          state_q <= ST_BL_RDB;
          cmd_q   <= CMD_BL_RDB;
        end
        ST_BL_RDB: begin
          state_q <= ST_BL_SUB;
          cmd_q   <= CMD_BL_SUB;
        end
        ST_BL_SUB: begin
          state_q <= ST_BL_MUL;
          cmd_q   <= CMD_BL_MUL;
        end
        ST_BL_MUL: begin
          state_q <= ST_BL_ADD;
          cmd_q   <= CMD_BL_ADD;
        end
        ST_BL_ADD: begin
          if (status_i.last_blend) begin
            state_q <= ST_FINISH;
            cmd_q   <= CMD_FINISH;
          end else begin
            state_q <= ST_BL_RDA;
            cmd_q   <= CMD_BL_RDA;
          end
        end
        ST_FINISH: begin
          if (status_i.can_publish) begin
            state_q <= ST_IDLE;
            cmd_q   <= CMD_IDLE;
            ready_q <= 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
          cmd_q   <= CMD_IDLE;
          ready_q <= 1'b1;
        end
      endcase
    end
  end

  assign cmd_o      = cmd_q;
  assign in_ready_o = ready_q;

endmodule

>>> rtl/tgi_datapath.sv
// Datapath: tables, sample store, search registers, divider and blend unit.
`timescale 1ns / 1ps
module tgi_datapath
  import tgi_pkg::*;
#(
  parameter int MAX_NODES_PER_AXIS = MAX_NODES_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_e                 cmd_i,
  output dp_status_t           status_o,
  input  logic                 in_fire_i,
  input  logic [2:0]           operation_i,
  input  logic [11:0]          address_i,
  input  logic signed [31:0]   write_value_i,
  input  logic signed [31:0]   query_x_i,
  input  logic signed [31:0]   query_y_i,
  input  logic signed [31:0]   query_z_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CNT_W-1:0]     cfg_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [31:0]   interp_value_o,
  output logic                 grid_invalid_o
);

  localparam int AW = $clog2(MAX_NODES_PER_AXIS);
  localparam int CW = $clog2(MAX_NODES_PER_AXIS + 1);
  localparam int SW = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int IDX_RAW = 3 * CW;
  localparam int IDX_W = (IDX_RAW > SMP_AW) ? IDX_RAW : SMP_AW + 1;
  localparam int DCW = $clog2(DIV_STEPS + 1);

  function automatic logic signed [31:0] ext(input logic [SW-1:0] v);
    return 32'($signed(v));
  endfunction

  function automatic logic [CW-1:0] sat_count(input logic [CNT_W-1:0] c);
    return (32'(c) > 32'(MAX_NODES_PER_AXIS)) ? CW'(MAX_NODES_PER_AXIS) : CW'(c);
  endfunction

  // Configuration registers.
  logic [CNT_W-1:0] cfg_q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[0] <= CNT_W'(2);
      cfg_q[1] <= CNT_W'(2);
      cfg_q[2] <= CNT_W'(2);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_X_COUNT: cfg_q[0] <= cfg_data_i;
        CFG_Y_COUNT: cfg_q[1] <= cfg_data_i;
        CFG_Z_COUNT: cfg_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [CW-1:0] eff_n [3];
  assign eff_n[0] = sat_count(cfg_q[0]);
  assign eff_n[1] = sat_count(cfg_q[1]);
  assign eff_n[2] = sat_count(cfg_q[2]);

  logic query_fire;
  assign query_fire = in_fire_i && (operation_i == OP_QUERY);

  // Query context.
  logic signed [31:0] q_q [3];
  logic [CW-1:0]      n_q [3];
  logic [1:0]         axis_q;
  logic [AW-1:0]      lo_q, hi_q, mid_q;
  logic [AW-1:0]      idx_q [3];
  logic [WGT_W-1:0]   wgt_q [3];
  logic signed [31:0] a_q;

  logic signed [31:0] q_sel;
  logic [CW-1:0]      n_sel;
  always_comb begin
    unique case (axis_q)
      AXIS_X: begin q_sel = q_q[0]; n_sel = n_q[0]; end
      AXIS_Y: begin q_sel = q_q[1]; n_sel = n_q[1]; end
      default: begin q_sel = q_q[2]; n_sel = n_q[2]; end
    endcase
  end

  // Axis node tables: one store, written by axis, read at one address a cycle.
  logic [SW-1:0] node_mem [3][MAX_NODES_PER_AXIS];
  logic [SW-1:0] node_rd_q;
  logic [AW-1:0] node_raddr;
  logic [AW:0]   mid_sum;
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};

  always_comb begin
    unique case (cmd_i)
      CMD_FIRST_CHK: node_raddr = AW'(n_sel - CW'(1));
      CMD_MID_RD:    node_raddr = mid_sum[AW:1];
      CMD_RD_LO:     node_raddr = lo_q;
      CMD_RD_HI:     node_raddr = lo_q + AW'(1);
      default:       node_raddr = '0;
    endcase
  end

  logic node_we;
  assign node_we = in_fire_i && (operation_i <= OP_WR_Z)
                   && (32'(address_i) < 32'(MAX_NODES_PER_AXIS));

  always_ff @(posedge clk_i) begin
    if (node_we) begin
      node_mem[operation_i[1:0]][address_i[AW-1:0]] <= write_value_i[SW-1:0];
    end
    node_rd_q <= node_mem[axis_q][node_raddr];
  end

  logic signed [31:0] rd_ext;
  assign rd_ext = ext(node_rd_q);

  logic [AW:0] span;
  assign span = {1'b0, hi_q} - {1'b0, lo_q};

  // Weight divider operands.
  logic signed [32:0] num_w, den_w;
  logic [32:0]        mag_n, mag_d;
  assign num_w = {q_sel[31], q_sel} - {a_q[31], a_q};
  assign den_w = {rd_ext[31], rd_ext} - {a_q[31], a_q};
  assign mag_n = num_w[32] ? 33'(-num_w) : 33'(num_w);
  assign mag_d = den_w[32] ? 33'(-den_w) : 33'(den_w);

  logic [33:0]        rem_q;
  logic [32:0]        dvs_q;
  logic [WGT_W-1:0]   wt_q;
  logic [DCW-1:0]     div_cnt_q;
  logic [33:0]        rem_sh;
  logic               rem_ge;
  assign rem_sh = {rem_q[32:0], 1'b0};
  assign rem_ge = rem_sh >= {1'b0, dvs_q};

  // Sample store and corner addressing.
  logic [SW-1:0]    smp_mem [SAMPLE_DEPTH];
  logic [SW-1:0]    smp_rd_q;
  logic             smp_zero_q;
  logic [IDX_W-1:0] t1_q, sx_q, base_q, corner_idx;
  logic [2:0]       k_q;
  logic             bx;
  assign bx = (cmd_i == CMD_BL_RDB);
  assign corner_idx = base_q + (bx ? sx_q : '0) + (k_q[1] ? IDX_W'(n_q[2]) : '0)
                      + IDX_W'(k_q[0]);

  always_ff @(posedge clk_i) begin
    if (in_fire_i && (operation_i == OP_WR_SAMPLE)) begin
      smp_mem[address_i] <= write_value_i[SW-1:0];
    end
    smp_rd_q   <= smp_mem[corner_idx[SMP_AW-1:0]];
    smp_zero_q <= (corner_idx >= IDX_W'(SAMPLE_DEPTH));
  end

  logic signed [31:0] smp_ext;
  assign smp_ext = smp_zero_q ? 32'sd0 : ext(smp_rd_q);

  // Blend unit.
  logic signed [31:0] c_q [7];
  logic signed [31:0] bl_a_q;
  logic signed [32:0] diff_q;
  logic signed [50:0] prod_q;
  logic signed [31:0] a_src, b_src;
  logic [WGT_W-1:0]   w_sel;
  logic signed [17:0] w_s;
  logic signed [31:0] blend_sum;

  always_comb begin
    unique case (k_q)
      3'd4: begin a_src = c_q[0]; b_src = c_q[2]; w_sel = wgt_q[1]; end
      3'd5: begin a_src = c_q[1]; b_src = c_q[3]; w_sel = wgt_q[1]; end
      3'd6: begin a_src = c_q[4]; b_src = c_q[5]; w_sel = wgt_q[2]; end
      default: begin a_src = smp_ext; b_src = smp_ext; w_sel = wgt_q[0]; end
    endcase
  end
  assign w_s = {1'b0, w_sel};
  // Arithmetic shift by 16 floors the product; the blend stays between its ends.
  assign blend_sum = bl_a_q + prod_q[47:16];

  logic signed [31:0] res_q;
  logic               inv_q;
  logic               out_valid_q;
  logic signed [31:0] out_value_q;
  logic               out_inv_q;
  logic               can_publish;
  assign can_publish = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q      <= AXIS_X;
      div_cnt_q   <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if ((cmd_i == CMD_FINISH) && can_publish) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (cmd_i)
        CMD_IDLE: begin
          if (query_fire) begin
            axis_q <= AXIS_X;
          end
        end
        CMD_DIV_INIT: begin
          if (den_w != '0 && num_w != '0 && num_w[32] == den_w[32]
              && mag_n < mag_d) begin
            div_cnt_q <= DCW'(DIV_STEPS);
          end else begin
            div_cnt_q <= '0;
          end
        end
        CMD_DIV_STEP: begin
          if (div_cnt_q != '0) begin
            div_cnt_q <= div_cnt_q - DCW'(1);
          end
        end
        CMD_AXIS_END: begin
          if (axis_q != AXIS_Z) begin
            axis_q <= axis_q + 2'd1;
          end
        end
        CMD_BASE1:    k_q <= '0;
        CMD_BL_ADD:   k_q <= k_q + 3'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      CMD_IDLE: begin
        if (query_fire) begin
          q_q[0] <= query_x_i;
          q_q[1] <= query_y_i;
          q_q[2] <= query_z_i;
          n_q[0] <= eff_n[0];
          n_q[1] <= eff_n[1];
          n_q[2] <= eff_n[2];
          res_q  <= 32'sd0;
          inv_q  <= status_o.grid_bad;
        end
      end
      CMD_FIRST_CHK: begin
        lo_q <= '0;
        hi_q <= AW'(n_sel - CW'(1));
      end
      CMD_LAST_CHK: begin
        if (q_sel >= rd_ext) begin
          lo_q <= AW'(n_sel - CW'(2));
        end
      end
      CMD_MID_RD: mid_q <= mid_sum[AW:1];
      CMD_MID_CHK: begin
        if (rd_ext <= q_sel) begin
          lo_q <= mid_q;
        end else begin
          hi_q <= mid_q;
        end
      end
      CMD_RD_HI: a_q <= rd_ext;
      CMD_DIV_INIT: begin
        rem_q <= {1'b0, mag_n};
        dvs_q <= mag_d;
        if (den_w != '0 && num_w != '0 && num_w[32] == den_w[32] && mag_n >= mag_d) begin
          wt_q <= ONE_Q16;
        end else begin
          wt_q <= '0;
        end
      end
      CMD_DIV_STEP: begin
        if (div_cnt_q != '0) begin
          rem_q <= rem_ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
          wt_q  <= {wt_q[WGT_W-2:0], rem_ge};
        end
      end
      CMD_AXIS_END: begin
        wgt_q[axis_q] <= wt_q;
        idx_q[axis_q] <= lo_q;
      end
      CMD_BASE1: begin
        t1_q <= IDX_W'(idx_q[0]) * IDX_W'(n_q[1]) + IDX_W'(idx_q[1]);
        sx_q <= IDX_W'(n_q[1]) * IDX_W'(n_q[2]);
      end
      CMD_BASE2: base_q <= t1_q * IDX_W'(n_q[2]) + IDX_W'(idx_q[2]);
      CMD_BL_RDB: bl_a_q <= a_src;
      CMD_BL_SUB: diff_q <= {b_src[31], b_src} - {bl_a_q[31], bl_a_q};
      CMD_BL_MUL: prod_q <= w_s * diff_q;
      CMD_BL_ADD: begin
        c_q[k_q] <= blend_sum;
        if (k_q == 3'd6) begin
          res_q <= blend_sum;
        end
      end
      CMD_FINISH: begin
        if (can_publish) begin
          out_value_q <= res_q;
          out_inv_q   <= inv_q;
        end
      end
      default: ;
    endcase
  end

  assign status_o.grid_bad    = (eff_n[0] < CW'(2)) || (eff_n[1] < CW'(2))
                                || (eff_n[2] < CW'(2));
  assign status_o.q_le_rd     = q_sel <= rd_ext;
  assign status_o.q_ge_rd     = q_sel >= rd_ext;
  assign status_o.search_done = span <= (AW + 1)'(1);
  assign status_o.div_busy    = div_cnt_q != '0;
  assign status_o.last_axis   = axis_q == AXIS_Z;
  assign status_o.last_blend  = k_q == 3'd6;
  assign status_o.can_publish = can_publish;

  assign out_valid_o    = out_valid_q;
  assign interp_value_o = out_value_q;
  assign grid_invalid_o = out_inv_q;

endmodule

>>> rtl/trilinear_grid_interp_core.sv
// Top level of the trilinear grid interpolator: controller, datapath and ports.
//
//   channel | dir | handshake    | payload
//   req     | in  | valid/ready  | operation, address, write_value, query_x/y/z
//   rsp     | out | valid/ready  | interp_value, grid_invalid
//   cfg     | in  | cfg_we_i     | cfg_idx_i, cfg_data_i (node counts)
//
// A write item is taken at once while the core is idle. Per axis, a query runs a binary
// search (at most log2 of the node count steps) and the 16-step weight divider, then
// address setup and seven blends through the one shared multiplier.
// Reset clears control state and sets each node count to 2; tables and samples are undefined until written.
// A finished result waits in the output register while new writes are taken; a
// following query finishes only once that result has been transferred.
`timescale 1ns / 1ps
module trilinear_grid_interp_core
  import tgi_pkg::*;
#(
  parameter int MAX_NODES_PER_AXIS = MAX_NODES_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  tgi_in_if.sink               req,
  tgi_out_if.source            rsp,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CNT_W-1:0]     cfg_data_i
);

  cmd_e       cmd;
  dp_status_t status;
  logic       in_ready;
  logic       in_fire;

  assign req.ready = in_ready;
  assign in_fire   = req.valid && in_ready;

  tgi_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .query_start_i (in_fire && (req.operation == OP_QUERY)),
    .status_i      (status),
    .cmd_o         (cmd),
    .in_ready_o    (in_ready)
  );

  tgi_datapath #(
    .MAX_NODES_PER_AXIS (MAX_NODES_PER_AXIS),
    .VALUE_BITS         (VALUE_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .in_fire_i      (in_fire),
    .operation_i    (req.operation),
    .address_i      (req.address),
    .write_value_i  (req.write_value),
    .query_x_i      (req.query_x),
    .query_y_i      (req.query_y),
    .query_z_i      (req.query_z),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (rsp.valid),
    .out_ready_i    (rsp.ready),
    .interp_value_o (rsp.interp_value),
    .grid_invalid_o (rsp.grid_invalid)
  );

endmodule
